// ===== sv/a64dp_pkg.sv =====
`timescale 1ns / 1ps

package a64dp_pkg;

	// Register file geometry
	localparam int unsigned RfDepth  = 31;
	localparam int unsigned XLen     = 64;
	localparam logic [4:0]  ZeroReg  = 5'd31;

	// Stream word widths (fields packed from bit 0, padded to whole bytes)
	localparam int unsigned SDataW   = 112;
	localparam int unsigned MDataW   = 80;

	// Instruction group codes, bits 28..24
	localparam logic [4:0]  GrpLogic  = 5'b01010;
	localparam logic [4:0]  GrpAddSub = 5'b01011;
	localparam logic [4:0]  GrpMul    = 5'b11011;

	// Reserved shift type for add/sub
	localparam logic [1:0]  ShiftRor  = 2'd3;

	// Command codes carried in the input user field
	typedef enum logic [1:0] {
		CmdExec      = 2'd0,
		CmdLoadReg   = 2'd1,
		CmdLoadFlags = 2'd2
	} cmd_t;

	// Logical opcodes, bits 30..29
	typedef enum logic [1:0] {
		OpcAnd  = 2'd0,
		OpcOrr  = 2'd1,
		OpcEor  = 2'd2,
		OpcAnds = 2'd3
	} logic_opc_t;

	// Second pipeline stage contents
	typedef struct packed {
		logic        handled;
		logic        mul;
		logic        wr;
		logic [4:0]  dest;
		logic [63:0] value;
		logic [3:0]  flags;
		logic        changed;
		logic        msub;
		logic        wide;
		logic [63:0] ll;
		logic [31:0] lh;
		logic [31:0] hl;
		logic [63:0] acc;
	} stage2_t;

endpackage

// ===== sv/a64_register_data_processing_unit.sv =====
`timescale 1ns / 1ps

// A64 data-processing (register) unit: executes MADD/MSUB, ADD/ADDS/SUB/SUBS
// and the shifted-register logical group (AND/BIC/ORR/ORN/EOR/EON/ANDS/BICS)
// in 64- and 32-bit forms against 31 general registers and NZCV, plus load
// commands that preset a register or the flags. One word is accepted per
// cycle while the output is free or taken; each gives one result word via
// stage one, stage two and the output register. The register file is two
// copies of a 31-entry memory (two read ports for Rn/Rm, one for Ra) with a
// registered read; results written back in stage two are forwarded to the
// operand stage. A multiply finishes its partial-product sum in stage two, so
// an execute word whose Rn, Rm or Ra field names the destination of the
// multiply right before it is held while that multiply is in stage one; every
// other sequence runs at one word per cycle while the output is taken. Reset
// clears per-entry valid bits: no clearing pass; unwritten registers read zero.
module a64_register_data_processing_unit
	import a64dp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// instruction[31:0], load_index[36:32], load_value[100:37], load_flags[104:101]
	input  logic [SDataW-1:0] s_axis_tdata,
	// command[1:0]
	input  logic [1:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// dest_index[4:0], dest_value[68:5], flags[72:69], flags_changed[73]
	output logic [MDataW-1:0] m_axis_tdata,
	// handled[0]
	output logic              m_axis_tuser
);

	// Register file copies and per-entry valid bits
	logic [XLen-1:0] mem_a [RfDepth];
	logic [XLen-1:0] mem_b [RfDepth];
	logic [RfDepth-1:0] rf_vld_q;
	logic [3:0] flags_q;

	// Stage 1 registers
	logic        vld_s1;
	logic [1:0]  cmd_s1;
	logic [31:0] ins_s1;
	logic [4:0]  lidx_s1;
	logic [63:0] lval_s1;
	logic [3:0]  lflg_s1;
	logic [63:0] rd_n_s1, rd_m_s1, rd_a_s1;
	logic        zn_s1, zm_s1, za_s1;

	// Stage 2 and output registers
	logic        vld_s2;
	stage2_t     stage_s2;
	logic        vld_s3;
	logic        hnd_s3;
	logic        wr_s3;
	logic [4:0]  dst_s3;
	logic [63:0] val_s3;
	logic [3:0]  flg_s3;
	logic        chg_s3;

	logic en;
	logic accept;
	logic hazard;

	// Input word fields
	logic [31:0] in_ins;
	logic [4:0]  in_lidx;
	logic [63:0] in_lval;
	logic [3:0]  in_lflg;
	logic [4:0]  in_rn, in_rm, in_ra;

	assign in_ins  = s_axis_tdata[31:0];
	assign in_lidx = s_axis_tdata[36:32];
	assign in_lval = s_axis_tdata[100:37];
	assign in_lflg = s_axis_tdata[104:101];
	assign in_rn   = in_ins[9:5];
	assign in_rm   = in_ins[20:16];
	assign in_ra   = in_ins[14:10];

	// Stage 1 decode
	cmd_t        cmd_e;
	logic        wide;
	logic [1:0]  opc;
	logic [4:0]  grp;
	logic [1:0]  stype;
	logic        nbit;
	logic [5:0]  imm6;
	logic [4:0]  rn, rm, ra, rd;
	logic [63:0] mask;
	logic [63:0] op_a, op_m, op_acc;
	logic        amt_ok, is_log, is_as, is_mul;
	logic [5:0]  amt;
	logic [63:0] sh;
	logic [63:0] lb, lres;
	logic        sub;
	logic [63:0] bb, ares;
	logic [64:0] sum;
	logic        carry, ovf;
	logic        res_handled, res_setf, res_mul;
	logic [4:0]  res_dest;
	logic [63:0] res_value;
	logic [3:0]  res_nzcv;
	logic [3:0]  nzcv_next;

	// Stage 2 multiply completion
	logic [63:0] mask2, prod, mul_r, value2;

	function automatic logic top_bit(input logic [63:0] x, input logic w);
		top_bit = w ? x[63] : x[31];
	endfunction

	// Pick an operand: zero register, in-flight result, or memory data
	function automatic logic [63:0] fwd_operand(
		input logic [4:0]  idx,
		input logic [63:0] rdata,
		input logic        rzero,
		input logic        s2_hit,
		input logic [4:0]  s2_dest,
		input logic [63:0] s2_val,
		input logic        s3_hit,
		input logic [4:0]  s3_dest,
		input logic [63:0] s3_val
	);
		logic [63:0] r;
		if (idx == ZeroReg) begin
			r = '0;
		end else if (s2_hit && s2_dest == idx) begin
			r = s2_val;
		end else if (s3_hit && s3_dest == idx) begin
			r = s3_val;
		end else if (rzero) begin
			r = '0;
		end else begin
			r = rdata;
		end
		fwd_operand = r;
	endfunction

	function automatic logic [63:0] shift_op(
		input logic [1:0]  t,
		input logic [63:0] v,
		input logic [5:0]  a,
		input logic        w
	);
		logic [31:0]  v32;
		logic [63:0]  d32;
		logic [127:0] d64;
		logic [63:0]  r;
		v32 = v[31:0];
		d32 = {v32, v32} >> a[4:0];
		d64 = {v, v} >> a;
		unique case (t)
			2'd0: r = w ? (v << a) : {32'b0, v32 << a[4:0]};
			2'd1: r = w ? (v >> a) : {32'b0, v32 >> a[4:0]};
			2'd2: r = w ? unsigned'($signed(v) >>> a)
			            : {32'b0, unsigned'($signed(v32) >>> a[4:0])};
			2'd3: r = w ? d64[63:0] : {32'b0, d32[31:0]};
		endcase
		shift_op = r;
	endfunction

	// Advance the pipeline when the output register is free or taken
	assign en = !vld_s3 || m_axis_tready;

	// Hold a word that reads the destination of a multiply in stage 1
	assign hazard = vld_s1 && res_mul && res_dest != ZeroReg &&
		cmd_t'(s_axis_tuser) == CmdExec &&
		(in_rn == res_dest || in_rm == res_dest || in_ra == res_dest);

	assign s_axis_tready = en && !hazard;
	assign accept = s_axis_tvalid && s_axis_tready;

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= accept;
		end
	end

	// Capture the input word and read the register file
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1  <= s_axis_tuser;
			ins_s1  <= in_ins;
			lidx_s1 <= in_lidx;
			lval_s1 <= in_lval;
			lflg_s1 <= in_lflg;
			rd_n_s1 <= mem_a[in_rn];
			rd_m_s1 <= mem_a[in_rm];
			rd_a_s1 <= mem_b[in_ra];
			zn_s1   <= in_rn == ZeroReg || !rf_vld_q[in_rn];
			zm_s1   <= in_rm == ZeroReg || !rf_vld_q[in_rm];
			za_s1   <= in_ra == ZeroReg || !rf_vld_q[in_ra];
		end
	end

	// Decode fields and gather operands
	always_comb begin
		cmd_e  = cmd_t'(cmd_s1);
		wide   = ins_s1[31];
		opc    = ins_s1[30:29];
		grp    = ins_s1[28:24];
		stype  = ins_s1[23:22];
		nbit   = ins_s1[21];
		imm6   = ins_s1[15:10];
		rn     = ins_s1[9:5];
		rm     = ins_s1[20:16];
		ra     = ins_s1[14:10];
		rd     = ins_s1[4:0];
		mask   = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
		op_a   = mask & fwd_operand(rn, rd_n_s1, zn_s1, vld_s2 && stage_s2.wr,
			stage_s2.dest, stage_s2.value, vld_s3 && wr_s3, dst_s3, val_s3);
		op_m   = mask & fwd_operand(rm, rd_m_s1, zm_s1, vld_s2 && stage_s2.wr,
			stage_s2.dest, stage_s2.value, vld_s3 && wr_s3, dst_s3, val_s3);
		op_acc = mask & fwd_operand(ra, rd_a_s1, za_s1, vld_s2 && stage_s2.wr,
			stage_s2.dest, stage_s2.value, vld_s3 && wr_s3, dst_s3, val_s3);
		amt_ok = wide || !imm6[5];
		is_log = grp == GrpLogic && amt_ok;
		is_as  = grp == GrpAddSub && !nbit && stype != ShiftRor && amt_ok;
		is_mul = grp == GrpMul && opc == 2'd0 && ins_s1[23:21] == 3'd0;
		amt    = wide ? imm6 : {1'b0, imm6[4:0]};
	end

	// Shift, logical and add/sub datapath
	always_comb begin
		sh = shift_op(stype, op_m, amt, wide);
		lb = nbit ? (sh ^ mask) : sh;
		unique case (logic_opc_t'(opc))
			OpcAnd:  lres = op_a & lb;
			OpcOrr:  lres = op_a | lb;
			OpcEor:  lres = op_a ^ lb;
			OpcAnds: lres = op_a & lb;
		endcase
		sub   = opc[1];
		bb    = (sub ? ~sh : sh) & mask;
		sum   = {1'b0, op_a} + {1'b0, bb} + {64'b0, sub};
		ares  = sum[63:0] & mask;
		carry = wide ? sum[64] : sum[32];
		ovf   = top_bit(~(op_a ^ bb) & (op_a ^ ares), wide);
	end

	// Select the stage 1 result
	always_comb begin
		res_handled = 1'b0;
		res_dest    = ZeroReg;
		res_value   = '0;
		res_setf    = 1'b0;
		res_mul     = 1'b0;
		res_nzcv    = flags_q;
		unique case (cmd_e)
			CmdExec: begin
				if (is_log) begin
					res_handled = 1'b1;
					res_dest    = rd;
					res_value   = lres;
					if (logic_opc_t'(opc) == OpcAnds) begin
						res_setf = 1'b1;
						res_nzcv = {top_bit(lres, wide), lres == 64'd0, 2'b00};
					end
				end else if (is_as) begin
					res_handled = 1'b1;
					res_dest    = rd;
					res_value   = ares;
					if (opc[0]) begin
						res_setf = 1'b1;
						res_nzcv = {top_bit(ares, wide), ares == 64'd0, carry, ovf};
					end
				end else if (is_mul) begin
					res_handled = 1'b1;
					res_dest    = rd;
					res_mul     = 1'b1;
				end
			end
			CmdLoadReg: begin
				res_handled = 1'b1;
				res_dest    = lidx_s1;
				res_value   = lval_s1;
			end
			CmdLoadFlags: begin
				res_handled = 1'b1;
				res_nzcv    = lflg_s1;
			end
			default: begin
				res_handled = 1'b0;
			end
		endcase
		nzcv_next = res_nzcv;
	end

	// Commit flags in order as words leave stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (en && vld_s1) begin
			flags_q <= nzcv_next;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	// Stage 2 payload, multiply partial products
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2.handled <= res_handled;
			stage_s2.mul     <= res_mul;
			stage_s2.wr      <= res_handled && res_dest != ZeroReg;
			stage_s2.dest    <= res_dest;
			stage_s2.value   <= res_value;
			stage_s2.flags   <= nzcv_next;
			stage_s2.changed <= res_setf;
			stage_s2.msub    <= ins_s1[15];
			stage_s2.wide    <= wide;
			stage_s2.ll      <= op_a[31:0] * op_m[31:0];
			stage_s2.lh      <= 32'(op_a[31:0] * op_m[63:32]);
			stage_s2.hl      <= 32'(op_a[63:32] * op_m[31:0]);
			stage_s2.acc     <= op_acc;
		end
	end

	// Finish the multiply-accumulate
	always_comb begin
		mask2  = stage_s2.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
		prod   = stage_s2.ll + {stage_s2.lh + stage_s2.hl, 32'b0};
		mul_r  = (stage_s2.msub ? stage_s2.acc - prod : stage_s2.acc + prod) & mask2;
		value2 = stage_s2.mul ? mul_r : stage_s2.value;
	end

	// Write back to both register file copies
	always_ff @(posedge clk) begin
		if (en && vld_s2 && stage_s2.wr) begin
			mem_a[stage_s2.dest] <= value2;
			mem_b[stage_s2.dest] <= value2;
		end
	end

	// Mark written entries valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
		end else if (en && vld_s2 && stage_s2.wr) begin
			rf_vld_q[stage_s2.dest] <= 1'b1;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (en) begin
			hnd_s3 <= stage_s2.handled;
			wr_s3  <= stage_s2.wr;
			dst_s3 <= stage_s2.dest;
			val_s3 <= value2;
			flg_s3 <= stage_s2.flags;
			chg_s3 <= stage_s2.changed;
		end
	end

	// Drive the result word
	assign m_axis_tvalid = vld_s3;
	assign m_axis_tuser  = hnd_s3;
	assign m_axis_tdata  = {6'b0, chg_s3, flg_s3, val_s3, dst_s3};

endmodule
